/* rtl/pmdc_pkg.sv */
package pmdc_pkg;

    // Fixed field widths
    localparam int CH_W      = 3;
    localparam int FRAME_W   = 13;
    localparam int LEVEL_W   = 24;
    localparam int FACTOR_W  = 24;
    localparam int ACC_W     = 25;
    localparam int FRAC_W    = 24;
    localparam int CNT_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Output word layout: out_channel, level, clip_level, zero pad
    localparam int M_FIELDS_W = CH_W + 2 * LEVEL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Fixed-point constants
    localparam logic [LEVEL_W-1:0] ONE_Q21   = LEVEL_W'(1 << 21);
    localparam logic [ACC_W-1:0]   ONE_Q24   = ACC_W'(1 << 24);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(1 << 23);
    localparam logic [CNT_W-1:0]   OVER_LIMIT = CNT_W'(3);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_DECAY = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = CFG_IDX_W'(2);

    // Input command codes
    localparam logic CMD_DECAY  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_MUL_AP,
        ST_MUL_BP,
        ST_MUL_AC,
        ST_MUL_BC,
        ST_MUL_LP,
        ST_MUL_LC,
        ST_RESP
    } pmdc_state_t;

endpackage

/* rtl/pmdc_mul.sv */
module pmdc_mul (
    input  logic [pmdc_pkg::ACC_W-1:0] a,
    input  logic [pmdc_pkg::ACC_W-1:0] b,
    output logic [pmdc_pkg::ACC_W-1:0] p
);
    import pmdc_pkg::*;

    logic [2*ACC_W-1:0] product;

    // Full product, keep bits above the 24 fraction bits (Q1.24 scaling)
    assign product = a * b;
    assign p       = product[FRAC_W +: ACC_W];

endmodule

/* rtl/peak_meter_decay_clip_core.sv */
// Sample word: latched on accept, applied in ST_SAMPLE, result registered from ST_RESP.
// The next word can be accepted in ST_RESP while the result is handed off, if the output is free.
// Decay word: square-and-multiply over the bits of the saturated frame count (AP, BP, AC, BC
// per bit), then level scaling (LP, LC), all on the single shared 25x25 multiplier.
// Zero frame count, inactive meter sample or out-of-range channel: straight to ST_RESP.
// Reset (aresetn low, synchronous): levels, over counts cleared, registers to defaults.
module peak_meter_decay_clip_core #(
    parameter int CHANNELS    = 8,
    parameter int MAX_FRAMES  = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic aclk,
    input  logic aresetn,

    // Input stream
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // channel[2:0], frame_count[15:3], sample[16+SAMPLE_BITS-1:16], zero pad
    input  logic [((16 + SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    // command[0]
    input  logic [0:0]                                 s_tuser,

    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_channel[2:0], level[26:3], clip_level[50:27], zero pad
    output logic [pmdc_pkg::M_TDATA_W-1:0]  m_tdata,

    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pmdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pmdc_pkg::FACTOR_W-1:0]     cfg_data
);
    import pmdc_pkg::*;

    localparam int DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SOFF  = CH_W + FRAME_W;

    pmdc_state_t state_reg, state_next;

    logic [FACTOR_W-1:0] decay_factor_reg, clip_decay_factor_reg;
    logic                meter_active_reg;

    logic [LEVEL_W-1:0] peak_levels_reg [DEPTH];
    logic [LEVEL_W-1:0] clip_levels_reg [DEPTH];
    logic [CNT_W-1:0]   over_counts_reg [DEPTH];

    logic                   cmd_reg;
    logic [CH_W-1:0]        chan_reg;
    logic                   in_range_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [FRAME_W-1:0]     n_reg;
    logic [ACC_W-1:0]       acc_p_reg, acc_c_reg;
    logic [FACTOR_W-1:0]    base_p_reg, base_c_reg;

    logic                m_tvalid_reg;
    logic [CH_W-1:0]     out_chan_reg;
    logic [LEVEL_W-1:0]  out_level_reg, out_clip_reg;

    // Input word decode
    logic                   in_cmd;
    logic [CH_W-1:0]        in_chan;
    logic [FRAME_W-1:0]     in_frames, frames_sat;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic                   in_range;
    logic                   accept;
    logic                   out_free;
    logic                   load_out;
    pmdc_state_t            dispatch;

    assign in_cmd    = s_tuser[0];
    assign in_chan   = s_tdata[CH_W-1:0];
    assign in_frames = s_tdata[CH_W +: FRAME_W];
    assign in_sample = s_tdata[SOFF +: SAMPLE_BITS];
    assign in_range  = 32'(in_chan) < CHANNELS;
    assign frames_sat = (32'(in_frames) > MAX_FRAMES) ? FRAME_W'(MAX_FRAMES) : in_frames;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    logic [IDX_W-1:0] idx;
    assign idx = chan_reg[IDX_W-1:0];

    // Choose the first state for a new word
    always_comb begin
        priority if (!in_range) begin
            dispatch = ST_RESP;
        end else if (in_cmd == CMD_SAMPLE) begin
            dispatch = meter_active_reg ? ST_SAMPLE : ST_RESP;
        end else if (frames_sat == '0) begin
            dispatch = ST_RESP;
        end else begin
            dispatch = ST_MUL_AP;
        end
    end

    // Sequencer: next state and handshake
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) state_next = dispatch;
            end
            ST_SAMPLE: state_next = ST_RESP;
            ST_MUL_AP: state_next = ST_MUL_BP;
            ST_MUL_BP: state_next = ST_MUL_AC;
            ST_MUL_AC: state_next = ST_MUL_BC;
            ST_MUL_BC: begin
                state_next = (n_reg[FRAME_W-1:1] == '0) ? ST_MUL_LP : ST_MUL_AP;
            end
            ST_MUL_LP: state_next = ST_MUL_LC;
            ST_MUL_LC: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    s_tready   = 1'b1;
                    state_next = s_tvalid ? dispatch : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Shared multiplier operand select
    logic [ACC_W-1:0] mul_a, mul_b, mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_AP: begin mul_a = acc_p_reg;              mul_b = {1'b0, base_p_reg}; end
            ST_MUL_BP: begin mul_a = {1'b0, base_p_reg};     mul_b = {1'b0, base_p_reg}; end
            ST_MUL_AC: begin mul_a = acc_c_reg;              mul_b = {1'b0, base_c_reg}; end
            ST_MUL_BC: begin mul_a = {1'b0, base_c_reg};     mul_b = {1'b0, base_c_reg}; end
            ST_MUL_LP: begin mul_a = {1'b0, peak_levels_reg[idx]}; mul_b = acc_p_reg; end
            ST_MUL_LC: begin mul_a = {1'b0, clip_levels_reg[idx]}; mul_b = acc_c_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    pmdc_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    // Sample magnitude, saturated to 2^23
    logic signed [SAMPLE_BITS:0] sample_ext;
    logic [SAMPLE_BITS:0]        mag_wide;
    logic [LEVEL_W-1:0]          mag;
    logic [LEVEL_W-1:0]          peak_new;
    logic                        over;
    logic [CNT_W-1:0]            cnt_new;

    always_comb begin
        sample_ext = {sample_reg[SAMPLE_BITS-1], sample_reg};
        mag_wide   = sample_reg[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'(-sample_ext)
                                               : (SAMPLE_BITS+1)'(sample_ext);
        mag = (33'(mag_wide) > 33'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(mag_wide);
        peak_new = (mag > peak_levels_reg[idx]) ? mag : peak_levels_reg[idx];
        over     = peak_new > ONE_Q21;
        if (!over) begin
            cnt_new = '0;
        end else if (over_counts_reg[idx] < OVER_LIMIT) begin
            cnt_new = over_counts_reg[idx] + CNT_W'(1);
        end else begin
            cnt_new = over_counts_reg[idx];
        end
    end

    // Channel state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                peak_levels_reg[i] <= '0;
                clip_levels_reg[i] <= '0;
                over_counts_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                ST_SAMPLE: begin
                    peak_levels_reg[idx] <= peak_new;
                    over_counts_reg[idx] <= cnt_new;
                    if (cnt_new >= OVER_LIMIT) clip_levels_reg[idx] <= ONE_Q21;
                end
                ST_MUL_LP: peak_levels_reg[idx] <= mul_p[LEVEL_W-1:0];
                ST_MUL_LC: clip_levels_reg[idx] <= mul_p[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Latch the word and run the power loop
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= in_cmd;
            chan_reg     <= in_chan;
            in_range_reg <= in_range;
            sample_reg   <= in_sample;
            n_reg        <= frames_sat;
            acc_p_reg    <= ONE_Q24;
            acc_c_reg    <= ONE_Q24;
            base_p_reg   <= decay_factor_reg;
            base_c_reg   <= clip_decay_factor_reg;
        end else begin
            unique case (state_reg)
                ST_MUL_AP: if (n_reg[0]) acc_p_reg <= mul_p;
                ST_MUL_BP: base_p_reg <= mul_p[FACTOR_W-1:0];
                ST_MUL_AC: if (n_reg[0]) acc_c_reg <= mul_p;
                ST_MUL_BC: begin
                    base_c_reg <= mul_p[FACTOR_W-1:0];
                    n_reg      <= n_reg >> 1;
                end
                default: ;
            endcase
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_factor_reg      <= '0;
            clip_decay_factor_reg <= '0;
            meter_active_reg      <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DECAY:      decay_factor_reg      <= cfg_data;
                CFG_CLIP_DECAY: clip_decay_factor_reg <= cfg_data;
                CFG_ACTIVE:     meter_active_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_chan_reg  <= chan_reg;
            out_level_reg <= in_range_reg ? peak_levels_reg[idx] : '0;
            out_clip_reg  <= in_range_reg ? clip_levels_reg[idx] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_clip_reg, out_level_reg, out_chan_reg};

    // Checks
    a_ready_only_idle_or_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE || state_reg == ST_RESP))
        else $error("input ready outside idle or response");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    a_loop_done_before_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_LP) |-> (n_reg == '0 && cmd_reg == CMD_DECAY))
        else $error("level scaling before power loop finished");

    a_level_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_level_reg <= LEVEL_MAX && out_clip_reg <= LEVEL_MAX))
        else $error("reported level above full scale");

endmodule
